// ===== sv/kclc_pkg.sv =====
// kclc_pkg: shared types and constants of the keypad code lock controller.
// No dependencies; imported by the controller, the datapath and the top level.

package kclc_pkg;

    // Geometry of one stored access code
    localparam int CODE_BYTES   = 16;
    localparam int CODE_W       = 8 * CODE_BYTES;
    localparam int LEN_W        = 5;
    localparam int MIN_CODE_LEN = 4;

    // Timing constants
    localparam logic [31:0] IDLE_DEADLINE      = 32'd4294967290;
    localparam logic [31:0] DEFAULT_AUTO_CLOSE = 32'd5000;
    localparam logic [31:0] AUTOMATION_GUARD   = 32'd500;

    // Byte that ends a stored code; an erased slot is all of these
    localparam logic [7:0] END_BYTE = 8'hFF;

    // Trailing bytes 13..15 of the typed code that switch an open door
    localparam logic [23:0] SFX_HOLD_OPEN = 24'h0A010A;
    localparam logic [23:0] SFX_NORMAL    = 24'h0A020A;

    // Factory reset code, 13 bytes, compared with the typed trailing bytes
    localparam int          WIPE_LEN  = 13;
    localparam logic [103:0] WIPE_CODE = 104'h00000000_01020301_01080204_03;

    // Mode command codes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_HELD   = 2'd1;
    localparam logic [1:0] MODE_FORCED = 2'd2;

    // Input transaction kinds
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_CODE  = 2'd1,
        ACT_MODE  = 2'd2,
        ACT_WRITE = 2'd3
    } action_t;

    // How the datapath resolves the current item
    typedef enum logic [1:0] {
        CK_DIRECT = 2'd0,
        CK_MATCH  = 2'd1,
        CK_WIPE   = 2'd2,
        CK_MISS   = 2'd3
    } commit_kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_EXEC  = 3'd2,
        ST_SCAN  = 3'd3,
        ST_DONE  = 3'd4
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic         capture;
        logic         clear_run;
        logic         scan_start;
        logic         scan_run;
        logic         commit;
        commit_kind_t kind;
    } kclc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        action_t act;
        logic    suffix_cmd;
        logic    scan_hit;
        logic    scan_end;
        logic    wipe_hit;
        logic    clear_last;
        logic    out_free;
    } kclc_status_t;

endpackage

// ===== sv/keypad_code_lock_controller.sv =====
// keypad_code_lock_controller: top level, joins the controller and the datapath.
// Depends on kclc_pkg, kclc_ctrl, kclc_datapath and kclc_ram.
//
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    s_tuser action, s_tdata item fields
// m_        out        m_tvalid / m_tready    m_tdata result fields
// cfg_      in         cfg_wen (no wait)      cfg_wdata auto_close_ms
//
// Tick, mode and write items go from accept through ST_EXEC and ST_DONE
// to the result register. A code entry scans the table one slot read per cycle
// on the single read port, stopping at the first slot that matches.
// After reset, and after the factory reset code, a clearing pass writes every slot
// to all 0xFF, during which s_tready is low.
// One item is in work at a time; the next is accepted while a result waits in m_.

module keypad_code_lock_controller
    import kclc_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] action
    input  logic [1:0]   s_tuser,
    // [31:0] now_ms, [95:32] code_high, [159:96] code_low, [161:160] mode_code,
    // [172:162] slot_number, [175:173] zero
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] door_open, [1] drive_unlock, [2] drive_lock, [3] automation_pulse,
    // [14:4] matched_slot, [15] factory_reset
    output logic [15:0]  m_tdata,
    input  logic         cfg_wen,
    input  logic [31:0]  cfg_wdata
);

    kclc_cmd_t    cmd;
    kclc_status_t sts;

    kclc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kclc_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_action      (s_tuser),
        .in_now_ms      (s_tdata[31:0]),
        .in_code_high   (s_tdata[95:32]),
        .in_code_low    (s_tdata[159:96]),
        .in_mode_code   (s_tdata[161:160]),
        .in_slot_number (s_tdata[172:162]),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

`ifndef SYNTHESIS
    // One item in work at a time: no accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // Lock and unlock pulses exclude each other
    a_pulse_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("drive_unlock and drive_lock in one result");

    // Automation fires only with the door released
    a_auto_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[0])
        else $error("automation pulse on a locked door");

    // Factory reset leaves a locked door and no matched slot
    a_wipe_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> !m_tdata[0] && m_tdata[14:4] == 11'd0 && !m_tdata[3])
        else $error("factory reset result carries other events");
`endif

endmodule

// ===== sv/kclc_ram.sv =====
// kclc_ram: generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.

module kclc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/kclc_ctrl.sv =====
// kclc_ctrl: sequencing state machine of the keypad code lock controller.
// Depends on kclc_pkg; drives the datapath through kclc_cmd_t only.

module kclc_ctrl
    import kclc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  kclc_status_t sts,
    output kclc_cmd_t    cmd
);

    state_t       state_reg, state_next;
    commit_kind_t kind_reg, kind_next;

    // State register; reset starts with the table clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            kind_reg  <= CK_MISS;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.kind       = kind_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_run = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // code entries without a suffix command go through the table
                if (sts.act == ACT_CODE && !sts.suffix_cmd) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    kind_next  = CK_DIRECT;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_hit) begin
                    kind_next  = CK_MATCH;
                    state_next = ST_DONE;
                end else if (sts.scan_end) begin
                    kind_next  = sts.wipe_hit ? CK_WIPE : CK_MISS;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // commit state and result together once the output register frees
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = (kind_reg == CK_WIPE) ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/kclc_datapath.sv =====
// kclc_datapath: item capture, lock state, code table with scan pipeline, result register.
// Depends on kclc_pkg and kclc_ram; controlled by kclc_ctrl via kclc_cmd_t.

module kclc_datapath
    import kclc_pkg::*;
#(
    parameter int SLOTS = 1024,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  kclc_cmd_t     cmd,
    output kclc_status_t  sts,
    input  logic [1:0]    in_action,
    input  logic [31:0]   in_now_ms,
    input  logic [63:0]   in_code_high,
    input  logic [63:0]   in_code_low,
    input  logic [1:0]    in_mode_code,
    input  logic [10:0]   in_slot_number,
    input  logic          cfg_wen,
    input  logic [31:0]   cfg_wdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata
);

    // Captured item
    action_t            act_reg;
    logic [31:0]        now_reg;
    logic [CODE_W-1:0]  typed_reg;
    logic [1:0]         mode_reg;
    logic [10:0]        slot_reg;

    // Lock state and register
    logic        open_reg, open_next;
    logic        force_reg, force_next;
    logic [31:0] dl_reg, dl_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] auto_close_reg;

    // Scan pipeline
    logic [CW-1:0]     iss_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]     idx1_reg, idx2_reg, idx3_reg;
    logic [AW-1:0]     hit_idx_reg;
    logic [CODE_W-1:0] align2_reg;
    logic [LEN_W-1:0]  len2_reg;
    logic              hit3_reg;
    logic [CODE_W-1:0] rdata;
    logic              issue;

    // Clearing pass
    logic [AW-1:0] clr_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [15:0] out_reg;

    // Commit results
    logic        unlock, lock, autop, fr, wr_item, guard_ok, slot_ok;
    logic [10:0] mslot;
    logic        sfx_open, sfx_normal, wipe_hit;

    // RAM port signals
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CODE_W-1:0] ram_wdata;

    // Length of a stored code: position of its first end byte
    function automatic logic [LEN_W-1:0] code_len(input logic [CODE_W-1:0] w);
        logic [LEN_W-1:0] n;
        n = LEN_W'(CODE_BYTES);
        for (int k = CODE_BYTES - 1; k >= 0; k--) begin
            if (w[CODE_W-1-8*k -: 8] == END_BYTE) begin
                n = LEN_W'(k);
            end
        end
        return n;
    endfunction

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= action_t'(in_action);
            now_reg   <= in_now_ms;
            typed_reg <= {in_code_high, in_code_low};
            mode_reg  <= in_mode_code;
            slot_reg  <= in_slot_number;
        end
    end

    // Suffix commands and factory reset code on the typed trailing bytes
    assign sfx_open   = open_reg && (typed_reg[23:0] == SFX_HOLD_OPEN);
    assign sfx_normal = open_reg && (typed_reg[23:0] == SFX_NORMAL);
    assign wipe_hit   = (typed_reg[8*WIPE_LEN-1:0] == WIPE_CODE);

    // Table scan: issue one read per cycle in slot order
    assign issue = cmd.scan_run && (iss_reg != CW'(SLOTS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else if (cmd.scan_start) begin
            iss_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else begin
            if (issue) begin
                iss_reg <= iss_reg + 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= cmd.scan_run && v1_reg;
            v3_reg <= cmd.scan_run && v2_reg;
        end
    end

    // Stage A: code length and right alignment of the stored bytes
    always_ff @(posedge aclk) begin
        logic [LEN_W-1:0] len;
        len        = code_len(rdata);
        idx1_reg   <= iss_reg[AW-1:0];
        idx2_reg   <= idx1_reg;
        len2_reg   <= len;
        align2_reg <= rdata >> {(LEN_W'(CODE_BYTES) - len), 3'b000};
    end

    // Stage B: compare with the trailing typed bytes
    always_ff @(posedge aclk) begin
        logic [CODE_W-1:0] mask;
        mask     = {CODE_W{1'b1}} >> {(LEN_W'(CODE_BYTES) - len2_reg), 3'b000};
        idx3_reg <= idx2_reg;
        hit3_reg <= (len2_reg >= LEN_W'(MIN_CODE_LEN))
                    && (((align2_reg ^ typed_reg) & mask) == '0);
    end

    // Slot of the first hit, held until the result is committed
    always_ff @(posedge aclk) begin
        if (cmd.scan_run && v3_reg && hit3_reg) begin
            hit_idx_reg <= idx3_reg;
        end
    end

    // Clearing pass address, wraps back to zero after the last slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_run) begin
            clr_reg <= (clr_reg == AW'(SLOTS - 1)) ? '0 : clr_reg + 1'b1;
        end
    end

    // Code table
    assign slot_ok   = (slot_reg != 11'd0) && (32'(slot_reg) <= SLOTS);
    assign ram_we    = cmd.clear_run || (cmd.commit && wr_item);
    assign ram_waddr = cmd.clear_run ? clr_reg : AW'(slot_reg - 11'd1);
    assign ram_wdata = cmd.clear_run ? {CODE_BYTES{END_BYTE}} : typed_reg;

    kclc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (iss_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Resolution of the item into next lock state and result fields
    assign guard_ok = (now_reg - last_reg) >= AUTOMATION_GUARD;

    always_comb begin
        open_next  = open_reg;
        force_next = force_reg;
        dl_next    = dl_reg;
        last_next  = last_reg;
        unlock     = 1'b0;
        lock       = 1'b0;
        autop      = 1'b0;
        fr         = 1'b0;
        wr_item    = 1'b0;
        mslot      = '0;
        case (cmd.kind)
            CK_DIRECT: begin
                unique case (act_reg)
                    ACT_TICK: begin
                        if (now_reg > dl_reg) begin
                            dl_next   = IDLE_DEADLINE;
                            lock      = 1'b1;
                            open_next = 1'b0;
                        end
                    end
                    ACT_CODE: begin
                        if (sfx_open) begin
                            dl_next    = IDLE_DEADLINE;
                            force_next = 1'b0;
                            open_next  = 1'b1;
                            unlock     = 1'b1;
                        end else if (sfx_normal) begin
                            force_next = 1'b0;
                            dl_next    = IDLE_DEADLINE;
                            lock       = 1'b1;
                            open_next  = 1'b0;
                        end
                    end
                    ACT_MODE: begin
                        unique case (mode_reg)
                            MODE_NORMAL: begin
                                force_next = 1'b0;
                                dl_next    = IDLE_DEADLINE;
                                lock       = 1'b1;
                                open_next  = 1'b0;
                            end
                            MODE_HELD: begin
                                force_next = 1'b0;
                                open_next  = 1'b1;
                                unlock     = 1'b1;
                            end
                            MODE_FORCED: begin
                                force_next = 1'b1;
                                dl_next    = IDLE_DEADLINE;
                                lock       = 1'b1;
                                open_next  = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    ACT_WRITE: begin
                        wr_item = slot_ok;
                    end
                    default: ;
                endcase
            end
            CK_MATCH: begin
                mslot = 11'(32'(hit_idx_reg) + 32'd1);
                if (!open_reg) begin
                    // forced locked: report the slot, keep the door shut
                    if (!force_reg) begin
                        dl_next   = now_reg + auto_close_reg;
                        open_next = 1'b1;
                        unlock    = 1'b1;
                        if (guard_ok) begin
                            last_next = now_reg;
                            autop     = 1'b1;
                        end
                    end
                end else if (guard_ok) begin
                    last_next = now_reg;
                    autop     = 1'b1;
                end
            end
            CK_WIPE: begin
                open_next  = 1'b0;
                force_next = 1'b0;
                dl_next    = IDLE_DEADLINE;
                last_next  = '0;
                fr         = 1'b1;
            end
            default: ;
        endcase
    end

    // Lock state registers, updated when the result is committed; cfg_wen loads auto_close_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg       <= 1'b0;
            force_reg      <= 1'b0;
            dl_reg         <= IDLE_DEADLINE;
            last_reg       <= '0;
            auto_close_reg <= DEFAULT_AUTO_CLOSE;
        end else begin
            if (cmd.commit) begin
                open_reg  <= open_next;
                force_reg <= force_next;
                dl_reg    <= dl_next;
                last_reg  <= last_next;
                if (fr) begin
                    auto_close_reg <= DEFAULT_AUTO_CLOSE;
                end
            end
            if (cfg_wen) begin
                auto_close_reg <= cfg_wdata;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= {fr, mslot, autop, lock, unlock, open_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // Status to the controller
    always_comb begin
        sts            = '0;
        sts.act        = act_reg;
        sts.suffix_cmd = sfx_open || sfx_normal;
        sts.scan_hit   = v3_reg && hit3_reg;
        sts.scan_end   = v3_reg && !hit3_reg && (idx3_reg == AW'(SLOTS - 1));
        sts.wipe_hit   = wipe_hit;
        sts.clear_last = clr_reg == AW'(SLOTS - 1);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule
